/* sv/extended_timer_with_idle_compare_top_assert.svh */
// Assertion macros for the extended timer with idle compare.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef EXTENDED_TIMER_WITH_IDLE_COMPARE_TOP_ASSERT_SVH
`define EXTENDED_TIMER_WITH_IDLE_COMPARE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ETIC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ETIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/etic_pkg.sv */
// Package for the extended timer with idle compare: item and result types,
// command and register codes, reset values. No dependencies.
package etic_pkg;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_IDLE = 2'd2;

  localparam logic [1:0] MODE_AWAKE      = 2'd0;
  localparam logic [1:0] MODE_POWER_SAVE = 2'd1;
  localparam logic [1:0] MODE_DEEP_SLEEP = 2'd2;

  localparam logic [1:0] REG_SLEEP_ENABLE = 2'd0;
  localparam logic [1:0] REG_STAY_AWAKE   = 2'd1;
  localparam logic [1:0] REG_DEEP_SLEEP   = 2'd2;

  localparam logic [15:0] RELOAD_VALUE       = 16'hFFFF;
  localparam logic        SLEEP_ENABLE_RESET = 1'b1;
  localparam logic [15:0] STAY_AWAKE_RESET   = 16'd16;
  localparam logic [15:0] DEEP_SLEEP_RESET   = 16'd1024;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] idle_duration;
  } in_item_t;

  typedef struct packed {
    logic [31:0] timer_value;
    logic [1:0]  sleep_mode;
    logic [15:0] sleep_ticks;
    logic        wake_event;
    logic        wrap_event;
  } out_item_t;

  typedef struct packed {
    logic        sleep_enable;
    logic [15:0] stay_awake_threshold;
    logic [15:0] deep_sleep_threshold;
  } cfg_t;

endpackage

/* sv/etic_stream_if.sv */
// Valid/ready stream interface carrying one payload of type T.
// No dependencies; the payload type is chosen where the interface is instantiated.
interface etic_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/etic_cfg.sv */
// Configuration register bank for the extended timer.
// Depends on etic_pkg.
module etic_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  output etic_pkg::cfg_t cfg_o
);
  import etic_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SLEEP_ENABLE: cfg_d.sleep_enable         = cfg_data_i[0];
        REG_STAY_AWAKE:   cfg_d.stay_awake_threshold = cfg_data_i;
        REG_DEEP_SLEEP:   cfg_d.deep_sleep_threshold = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sleep_enable         <= SLEEP_ENABLE_RESET;
      cfg_q.stay_awake_threshold <= STAY_AWAKE_RESET;
      cfg_q.deep_sleep_threshold <= DEEP_SLEEP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/etic_in_reg.sv */
// Input register stage: captures one command transaction and holds it
// until the engine consumes it. Depends on etic_pkg and etic_stream_if.
module etic_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  etic_stream_if.sink       in_if,
  input  logic              advance_i,
  output logic              valid_o,
  output etic_pkg::in_item_t item_o
);
  import etic_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q, item_d;
  logic     take;

  // The stage frees up in the same cycle the engine consumes it.
  assign in_if.ready = !valid_q || advance_i;
  assign take        = in_if.valid && in_if.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  assign item_d = take ? in_if.data : item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* sv/etic_engine.sv */
// Timer engine: counter, wrap count and compare state, the single-pass
// command logic and the result register. Depends on etic_pkg, etic_stream_if
// and the assertion macro header.
module etic_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  etic_pkg::in_item_t item_i,
  input  etic_pkg::cfg_t     cfg_i,
  output logic               advance_o,
  etic_stream_if.source      out_if
);
  import etic_pkg::*;

  logic [15:0] cnt_q, cnt_d;
  logic [15:0] wrap_q, wrap_d;
  logic [15:0] cmp_q, cmp_d;
  logic        res_valid_q, res_valid_d;
  out_item_t   res_q, res_d;

  logic [15:0] cnt_inc;
  logic [32:0] span;
  logic        reach_wrap;
  logic        idle_go;
  logic [15:0] sleep_time;

  // A transaction moves on when the result register is empty or being drained.
  assign advance_o = valid_i && (!res_valid_q || out_if.ready);

  assign cnt_inc    = cnt_q + 16'd1;
  assign span       = {17'd0, cnt_q} + {1'b0, item_i.idle_duration};
  assign reach_wrap = span >= {17'd0, RELOAD_VALUE};
  assign idle_go    = cfg_i.sleep_enable
                      && (item_i.idle_duration > {16'd0, cfg_i.stay_awake_threshold});
  // Below the wrap point the duration is known to fit in 16 bits.
  assign sleep_time = reach_wrap ? (RELOAD_VALUE - cnt_q) : item_i.idle_duration[15:0];

  always_comb begin
    cnt_d  = cnt_q;
    wrap_d = wrap_q;
    cmp_d  = cmp_q;
    res_d  = '0;
    unique case (item_i.command)
      CMD_TICK: begin
        cnt_d = cnt_inc;
        if (cnt_inc == cmp_q) begin
          res_d.wake_event = 1'b1;
          cmp_d            = RELOAD_VALUE;
        end
        if (cnt_inc == RELOAD_VALUE) begin
          res_d.wrap_event = 1'b1;
          wrap_d           = wrap_q + 16'd1;
        end
      end
      CMD_READ: begin
        res_d.timer_value = {wrap_q, cnt_inc};
      end
      CMD_IDLE: begin
        if (idle_go) begin
          if (!reach_wrap) begin
            cmp_d = cnt_q + item_i.idle_duration[15:0];
          end
          priority if (sleep_time > cfg_i.deep_sleep_threshold) begin
            res_d.sleep_mode = MODE_DEEP_SLEEP;
          end else if (sleep_time > cfg_i.stay_awake_threshold) begin
            res_d.sleep_mode = MODE_POWER_SAVE;
          end else begin
            res_d.sleep_mode = MODE_AWAKE;
          end
          res_d.sleep_ticks = sleep_time;
        end
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (advance_o) begin
      res_valid_d = 1'b1;
    end else if (out_if.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      wrap_q      <= '0;
      cmp_q       <= RELOAD_VALUE;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (advance_o) begin
        cnt_q  <= cnt_d;
        wrap_q <= wrap_d;
        cmp_q  <= cmp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid = res_valid_q;
  assign out_if.data  = res_q;

`include "extended_timer_with_idle_compare_top_assert.svh"

  // State only changes together with the result that reports it, so a
  // pending wrap result must still see the counter at the reload value.
  `ETIC_ASSERT_NOW(a_wrap_at_reload, res_valid_q && res_q.wrap_event, cnt_q == RELOAD_VALUE, "wrap result without counter at reload value")
  `ETIC_ASSERT_NOW(a_wake_restores_cmp, res_valid_q && res_q.wake_event, cmp_q == RELOAD_VALUE, "wake result without compare restored")
  `ETIC_ASSERT_NOW(a_idle_result_clean, res_valid_q && (res_q.sleep_ticks != 16'd0), (res_q.timer_value == 32'd0) && !res_q.wake_event && !res_q.wrap_event, "idle result carries tick or read fields")
  `ETIC_ASSERT_NEXT(a_count_only_on_tick, advance_o && (item_i.command != CMD_TICK), $stable(cnt_q) && $stable(wrap_q), "counter moved on a non-tick command")

endmodule

/* sv/extended_timer_with_idle_compare_top.sv */
// Extended timer with idle compare: a 16-bit tick counter widened to 32 bits by a wrap count,
// with a read command and an idle request. Depends on etic_pkg, etic_stream_if and the modules.
// A command transaction passes through the input register into the engine's result register.
// Throughput: one transaction per cycle unless the result sink stalls; the engine is single-pass.
// Reset (rst_ni, asynchronous, active low) clears counter and wrap count, sets compare
// to 0xFFFF and the configuration to enable 1, stay-awake 16 and deep-sleep 1024.
module extended_timer_with_idle_compare_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write port: register index 0 sleep enable, 1 stay-awake
  // threshold, 2 deep-sleep threshold. Index 3 is ignored.
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  // Command transactions in, result transactions out.
  etic_stream_if.sink   in_if,
  etic_stream_if.source out_if
);
  import etic_pkg::*;

  cfg_t     cfg;
  logic     stage_valid;
  in_item_t stage_item;
  logic     advance;

  // Configuration registers. The user must write them only while the timer is idle, so
  // the engine sees a settled set of thresholds for every transaction; the block does not enforce it.
  etic_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Input register. While a finished result waits at the output it can still
  // take one more transaction; after that the input stalls until the sink
  // drains the waiting result.
  etic_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_if),
    .advance_i (advance),
    .valid_o   (stage_valid),
    .item_o    (stage_item)
  );

  // Engine: all of one command's work happens in the cycle it moves from
  // the input register into the result register, state included, so the
  // next command sees the updated counter without any forwarding.
  etic_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (stage_valid),
    .item_i    (stage_item),
    .cfg_i     (cfg),
    .advance_o (advance),
    .out_if    (out_if)
  );

endmodule

/* test/etic_result_checker.sv */
// Result checker for the extended timer with idle compare: watches the command,
// result and configuration ports, predicts every result and compares it field by field.
// Depends on etic_pkg.
`timescale 1ns / 1ps

module etic_result_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  etic_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  etic_pkg::out_item_t out_item_i,
  output int                  fail_count_o,
  output int                  expected_left_o
);
  import etic_pkg::*;

  cfg_t        cfg_q;
  logic [15:0] low_q;
  logic [15:0] wraps_q;
  logic [15:0] compare_q;

  out_item_t   timer_results_q[$];
  out_item_t   want_item;
  int          failures;
  int          results_seen;

  assign fail_count_o = failures;

  task automatic report_mismatch(input string what);
    failures++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                results_seen, name, got, want));
    end
  endtask

  // Applies one command to the timer copy and returns the result it should give.
  function automatic out_item_t advance_timer(input in_item_t cmd_item);
    out_item_t   res;
    logic [15:0] sleep_time;
    logic [32:0] reach;
    res = '0;
    case (cmd_item.command)
      CMD_TICK: begin
        low_q = low_q + 16'd1;
        if (low_q == compare_q) begin
          res.wake_event = 1'b1;
          compare_q = RELOAD_VALUE;
        end
        if (low_q == RELOAD_VALUE) begin
          res.wrap_event = 1'b1;
          wraps_q = wraps_q + 16'd1;
        end
      end
      CMD_READ: begin
        res.timer_value = {wraps_q, low_q + 16'd1};
      end
      CMD_IDLE: begin
        if (cfg_q.sleep_enable &&
            cmd_item.idle_duration > {16'd0, cfg_q.stay_awake_threshold}) begin
          reach = {1'b0, cmd_item.idle_duration} + {17'd0, low_q};
          if (reach >= {17'd0, RELOAD_VALUE}) begin
            sleep_time = RELOAD_VALUE - low_q;
          end else begin
            sleep_time = cmd_item.idle_duration[15:0];
            compare_q = low_q + sleep_time;
          end
          if (sleep_time > cfg_q.deep_sleep_threshold) begin
            res.sleep_mode = MODE_DEEP_SLEEP;
          end else if (sleep_time > cfg_q.stay_awake_threshold) begin
            res.sleep_mode = MODE_POWER_SAVE;
          end else begin
            res.sleep_mode = MODE_AWAKE;
          end
          res.sleep_ticks = sleep_time;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sleep_enable         = SLEEP_ENABLE_RESET;
      cfg_q.stay_awake_threshold = STAY_AWAKE_RESET;
      cfg_q.deep_sleep_threshold = DEEP_SLEEP_RESET;
      low_q                      = '0;
      wraps_q                    = '0;
      compare_q                  = RELOAD_VALUE;
      timer_results_q.delete();
      failures                   = 0;
      results_seen               = 0;
      expected_left_o            = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (timer_results_q.size() == 0) begin
          report_mismatch("result transaction arrived with nothing expected");
        end else begin
          want_item = timer_results_q.pop_front();
          compare_field("timer_value", out_item_i.timer_value, want_item.timer_value);
          compare_field("sleep_mode", 32'(out_item_i.sleep_mode),
                        32'(want_item.sleep_mode));
          compare_field("sleep_ticks", 32'(out_item_i.sleep_ticks),
                        32'(want_item.sleep_ticks));
          compare_field("wake_event", 32'(out_item_i.wake_event),
                        32'(want_item.wake_event));
          compare_field("wrap_event", 32'(out_item_i.wrap_event),
                        32'(want_item.wrap_event));
        end
        results_seen++;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SLEEP_ENABLE: cfg_q.sleep_enable = cfg_data_i[0];
          REG_STAY_AWAKE:   cfg_q.stay_awake_threshold = cfg_data_i;
          REG_DEEP_SLEEP:   cfg_q.deep_sleep_threshold = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        timer_results_q.push_back(advance_timer(in_item_i));
      end
      expected_left_o = timer_results_q.size();
    end
  end

endmodule

/* test/extended_timer_with_idle_compare_top_tb.sv */
// Top of the testbench for the extended timer with idle compare: clock, reset,
// command stimulus, result back-pressure, configuration writes and the verdict.
// Depends on etic_pkg, etic_stream_if, the block itself and etic_result_checker.
`timescale 1ns / 1ps

module extended_timer_with_idle_compare_top_tb;
  import etic_pkg::*;

  // Codes the package leaves unnamed: the spare command and the spare register index.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int     HOLD_OFF_CYCLES = 300;
  localparam int     SETTLE_CYCLES   = 8;
  localparam int     SEGMENT_ITEMS   = 140;
  localparam longint RUN_LIMIT_NS    = 2_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  etic_stream_if #(.T(in_item_t))  cmd_ch ();
  etic_stream_if #(.T(out_item_t)) res_ch ();

  int          fail_count;
  int          expected_left;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_off_req;
  // Stay-awake threshold currently programmed, used to aim idle durations.
  logic [15:0] stay_now;

  extended_timer_with_idle_compare_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (cmd_ch),
    .out_if     (res_ch)
  );

  etic_result_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (cmd_ch.valid),
    .in_ready_i      (cmd_ch.ready),
    .in_item_i       (cmd_ch.data),
    .out_valid_i     (res_ch.valid),
    .out_ready_i     (res_ch.ready),
    .out_item_i      (res_ch.data),
    .fail_count_o    (fail_count),
    .expected_left_o (expected_left)
  );

  // 20 ns clock period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hard limit on the run. It sits well above the slowest legal run, which is
  // set by the segments where one side idles most of the time.
  initial begin
    #RUN_LIMIT_NS;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side. The ready line is redrawn at every falling edge from the current
  // idle percentage. When a hold-off is requested the ready line is held low for a
  // long, counted stretch so that the block fills up and has to stall its input.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one command transaction. It is entered at a falling edge and returns at
  // the falling edge after acceptance, with valid still high, so that a following
  // transaction can be offered back to back without valid dropping in between.
  task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] dur);
    in_item_t item;
    item.command       = cmd;
    item.idle_duration = dur;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= item;
    do @(posedge clk_i); while (!cmd_ch.ready);
    @(negedge clk_i);
  endtask

  // Stops offering commands and waits until every expected result has been seen,
  // then lets a few more cycles pass so that the block is certainly quiet.
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (expected_left != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // One register write, followed by a cycle with the write enable low.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  // Reprogrammes all three registers once the block has gone idle. Only bit 0 of
  // the enable word matters; the upper bits are there to show they are ignored.
  task automatic apply_config(input logic [15:0] enable_word, input logic [15:0] stay,
                              input logic [15:0] deep);
    drain_results();
    write_reg(REG_SLEEP_ENABLE, enable_word);
    write_reg(REG_STAY_AWAKE, stay);
    write_reg(REG_DEEP_SLEEP, deep);
    stay_now = stay;
  endtask

  // Random traffic. Most of it is an idle request that programs the compare
  // register, followed by roughly enough ticks to reach it, so that wake events
  // actually happen; reads are sprinkled in. The rest is unshaped noise over every
  // command (the spare one included) and idle requests aimed at the stay-awake
  // boundary.
  task automatic run_random(input int count);
    int          sent;
    int          pick;
    int          span;
    logic [31:0] dur;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        dur = {16'd0, stay_now} + 32'd1 + $urandom_range(0, 120);
        send_cmd(CMD_IDLE, dur);
        sent++;
        span = (dur < 32'd300) ? int'(dur) - 2 + int'($urandom_range(0, 4))
                               : int'($urandom_range(1, 40));
        repeat (span) begin
          if ($urandom_range(9) == 0) begin
            send_cmd(CMD_READ, $urandom);
          end else begin
            send_cmd(CMD_TICK, $urandom);
          end
          sent++;
        end
      end else if (pick < 85) begin
        send_cmd(2'($urandom_range(0, 3)), $urandom);
        sent++;
      end else begin
        send_cmd(CMD_IDLE, $urandom_range(0, int'(stay_now) + 2));
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    cmd_ch.valid  = 1'b0;
    cmd_ch.data   = '0;
    res_ch.ready  = 1'b0;
    hold_off_req  = 1'b0;
    stay_now      = STAY_AWAKE_RESET;
    // First phase: the sender idles now and then, the receiver most of the time.
    send_idle_pct = 30;
    recv_idle_pct = 85;

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed opening, with the reset configuration (stay-awake 16, deep 1024).
    // A read straight out of reset sees the counter adjusted by one.
    send_cmd(CMD_READ, 32'd0);
    // The spare command must change nothing and return an all-zero result.
    send_cmd(CMD_UNUSED, 32'hFFFF_FFFF);
    // Zero duration and a duration equal to the threshold are both ignored.
    send_cmd(CMD_IDLE, 32'd0);
    send_cmd(CMD_IDLE, 32'd16);
    // The largest duration runs past the wrap, so the sleep time is what is left
    // of the counter and compare is not touched.
    send_cmd(CMD_IDLE, 32'hFFFF_FFFF);
    // Either side of the deep-sleep threshold; both program compare.
    send_cmd(CMD_IDLE, 32'd1025);
    send_cmd(CMD_IDLE, 32'd1024);
    // Just above the stay-awake threshold, then tick up to the compare value so
    // that the seventeenth tick raises a wake event.
    send_cmd(CMD_IDLE, 32'd17);
    repeat (17) send_cmd(CMD_TICK, 32'd0);
    send_cmd(CMD_READ, 32'd0);
    // With the counter at 17: a duration that lands exactly on the reload value
    // takes the wrap path, one less programs compare to 0xFFFE.
    send_cmd(CMD_IDLE, 32'd65518);
    send_cmd(CMD_IDLE, 32'd65517);

    run_random(SEGMENT_ITEMS);

    // Both thresholds at zero: every non-zero duration sleeps, and deep sleep
    // wins. The spare register index is written too and must be ignored.
    apply_config(16'h0001, 16'd0, 16'd0);
    write_reg(REG_UNUSED, 16'hFFFF);
    run_random(SEGMENT_ITEMS);

    // Second phase: the sender idles most of the time, the receiver now and then.
    send_idle_pct = 85;
    recv_idle_pct = 30;
    // Sleep disabled through bit 0, with every other bit of the word set.
    apply_config(16'hFFFE, 16'($urandom), 16'($urandom));
    run_random(SEGMENT_ITEMS);
    // Both thresholds at their maximum: only durations beyond 16 bits sleep,
    // and then in the stay-awake mode with the remaining ticks reported.
    apply_config(16'h8001, 16'hFFFF, 16'hFFFF);
    run_random(SEGMENT_ITEMS);

    // Third phase: no idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_config(16'h0001, 16'd40, 16'd200);
    // Long receiver hold-off while the sender keeps pushing commands.
    hold_off_req = 1'b1;
    run_random(SEGMENT_ITEMS);

    // From wherever the counter stands: a read, a few idles just above the
    // stay-awake threshold, one that runs past the wrap, then ticks and a read.
    send_cmd(CMD_READ, $urandom);
    repeat (6) send_cmd(CMD_IDLE, {16'd0, stay_now} + 32'd1 + $urandom_range(0, 30));
    send_cmd(CMD_IDLE, 32'hFFFF_FFFF);
    repeat (20) send_cmd(CMD_TICK, $urandom);
    send_cmd(CMD_READ, $urandom);

    // Stay-awake at its minimum and deep sleep at its maximum.
    apply_config(16'h0001, 16'd0, 16'hFFFF);
    run_random(SEGMENT_ITEMS);

    drain_results();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
